[rtl/swmq_pkg.sv]
// Shared types, codes and constants for the sorted window mean query unit.
// No dependencies; swmq_cell and the top level refer to this package by scope.
package swmq_pkg;

	localparam int VALUE_W      = 32;   // stored value width, Q16.16
	localparam int COUNT_W      = 11;   // in_count field width
	localparam int SUM_W        = 42;   // window_sum field width
	localparam int MEAN_W       = 32;   // window_mean field width
	localparam int DEPTH_DEF    = 1024; // default store depth
	localparam int BND_W        = 50;   // window bound width, holds centre +/- half-width

	localparam logic [31:0] THRESH_RST = 32'hFFF6_0000; // -10.0
	localparam logic [31:0] SCALE_RST  = 32'h0001_0000; //  1.0

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_BUILD = 2'd2,
		REQ_QUERY = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_NO_BLD = 2'd2
	} status_t;

	typedef enum logic {
		CFG_THRESH = 1'b0,
		CFG_SCALE  = 1'b1
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_BOUND,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_PS_A,
		ST_PS_B,
		ST_PS_C,
		ST_DIV,
		ST_BLD_RD,
		ST_BLD_SETTLE,
		ST_BLD_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [VALUE_W-1:0] load_value;
		logic [VALUE_W-1:0] query_center;
		logic [31:0]        query_spread;
	} req_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0] in_count;
		logic [SUM_W-1:0]   window_sum;
		logic [MEAN_W-1:0]  window_mean;
		logic               mean_valid;
		logic [1:0]         status;
	} rsp_word_t;

	// One slot of the sorting chain.
	typedef struct packed {
		logic               vld;
		logic [VALUE_W-1:0] val;
	} cell_word_t;

	typedef struct packed {
		logic clear; // drop every held value
		logic shift; // move every held value one cell towards the head
	} cell_ctrl_t;

endpackage

[rtl/swmq_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module swmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/swmq_cell.sv]
// One cell of the systolic insertion sorter: keeps the smaller value, passes the larger on.
// Depends on swmq_pkg.
module swmq_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swmq_pkg::cell_ctrl_t ctrl,
	input  swmq_pkg::cell_word_t left_in,
	input  swmq_pkg::cell_word_t right_held,
	output swmq_pkg::cell_word_t held,
	output swmq_pkg::cell_word_t pass
);

	swmq_pkg::cell_word_t held_q;
	swmq_pkg::cell_word_t pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pass_q <= '0;
		end else if (ctrl.clear) begin
			held_q.vld <= 1'b0;
			pass_q.vld <= 1'b0;
		end else if (ctrl.shift) begin
			held_q     <= right_held;
			pass_q.vld <= 1'b0;
		end else if (left_in.vld) begin
			if (!held_q.vld) begin
				held_q     <= left_in;
				pass_q.vld <= 1'b0;
			end else if ($signed(left_in.val) < $signed(held_q.val)) begin
				// keep the newcomer, push the old one down
				held_q <= left_in;
				pass_q <= held_q;
			end else begin
				pass_q <= left_in;
			end
		end else begin
			pass_q.vld <= 1'b0;
		end
	end

	assign held = held_q;
	assign pass = pass_q;

endmodule

[rtl/sorted_window_mean_query_unit.sv]
// Top level of the sorted window mean query unit.
// Depends on swmq_pkg, swmq_cell and swmq_ram.
//
// Usage
//   req channel (req_valid/req_ready/req) takes one command word: clear, load, build or
//   query. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result word for each
//   command. cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the exclusion
//   threshold (index 0) or the window scale (index 1); it is always ready and must only
//   be used while no command is in flight.
// Sequencing (one command at a time, req_ready high only in idle)
//   clear, load : finish without the datapath and go straight to the result stage.
//   build       : the values stream from the value RAM into a chain of STORE_DEPTH
//                 sorting cells, settle, then drain one a cycle back into the RAM
//                 with prefix sums.
//   query       : set-up and the two binary searches (each probe costs a RAM read and a
//                 compare), then a one-bit-per-cycle restoring divider for the mean when
//                 the window is not empty.
// Reset clears the count, the built flag and the configuration registers to their defaults; RAM
// contents are not cleared. When rsp_ready is low the finished word is held in the
// output register and the next command waits in the result stage until it drains.
module sorted_window_mean_query_unit #(
	parameter int STORE_DEPTH = swmq_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  swmq_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output swmq_pkg::rsp_word_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int VW    = swmq_pkg::VALUE_W;
	localparam int PS_W  = VW + AW;             // prefix sum width, no overflow
	localparam int DC_W  = $clog2(PS_W + 1);    // divider step counter
	localparam int BW    = swmq_pkg::BND_W;

	swmq_pkg::state_t state_q, state_n;

	// configuration
	logic signed [31:0] thr_q, scale_q;

	// store bookkeeping
	logic [CNT_W-1:0] count_q;
	logic             built_q;

	// build sequencing
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W:0]   wait_q;
	logic             feed_vld_s1;
	logic [PS_W-1:0]  acc_q;

	// query operands and search
	logic signed [VW-1:0] center_q;
	logic signed [31:0]   spread_q;
	logic signed [63:0]   prod_q;
	logic signed [BW-1:0] lo_b_q, hi_b_q;
	logic [CNT_W-1:0]     lo_q, hi_q, first_q, past_q;
	logic                 sel_q;
	logic [PS_W-1:0]      psa_q;

	// divider
	logic [CNT_W-1:0] dcnt_q;
	logic [CNT_W:0]   rem_q;
	logic [PS_W-1:0]  dq_q;
	logic             neg_q;
	logic [DC_W-1:0]  step_q;

	swmq_pkg::rsp_word_t res_q, rsp_q;
	logic                rsp_valid_q;

	// RAM ports
	logic            vr_we, pr_we;
	logic [AW-1:0]   vr_waddr, vr_raddr, pr_waddr, pr_raddr;
	logic [VW-1:0]   vr_wdata, vr_rdata;
	logic [PS_W-1:0] pr_wdata, pr_rdata;

	// sort chain
	swmq_pkg::cell_ctrl_t cell_ctrl;
	swmq_pkg::cell_word_t feed_w;
	swmq_pkg::cell_word_t held_w [STORE_DEPTH];
	swmq_pkg::cell_word_t pass_w [STORE_DEPTH];

	logic                 req_acc;
	logic                 load_take;
	logic [CNT_W-1:0]     mid_w;
	logic signed [BW-1:0] probe_w;
	logic                 below_w;
	logic [PS_W-1:0]      drain_sum_w;
	logic [PS_W-1:0]      win_sum_w;
	logic [PS_W-1:0]      mag_w;
	logic [CNT_W:0]       rem_sh_w;
	logic                 ge_w;
	logic [CNT_W:0]       rem_n_w;
	logic [PS_W-1:0]      dq_n_w;
	swmq_pkg::rsp_word_t  idle_res_w;

	assign req_acc   = req_valid && req_ready;
	assign load_take = $signed(req.load_value) > thr_q;

	// midpoint of the live search interval
	assign mid_w   = lo_q + ((hi_q - lo_q) >> 1);
	assign probe_w = BW'($signed(vr_rdata));
	assign below_w = sel_q ? (probe_w < hi_b_q) : (probe_w <= lo_b_q);

	assign drain_sum_w = acc_q + {{(PS_W-VW){held_w[0].val[VW-1]}}, held_w[0].val};
	assign win_sum_w   = psa_q - ((first_q != '0) ? pr_rdata : '0);
	assign mag_w       = win_sum_w[PS_W-1] ? (~win_sum_w + 1'b1) : win_sum_w;

	// one restoring division step
	assign rem_sh_w = {rem_q[CNT_W-1:0], dq_q[PS_W-1]};
	assign ge_w     = rem_sh_w >= {1'b0, dcnt_q};
	assign rem_n_w  = ge_w ? (rem_sh_w - {1'b0, dcnt_q}) : rem_sh_w;
	assign dq_n_w   = {dq_q[PS_W-2:0], ge_w};

	assign feed_w.vld = feed_vld_s1;
	assign feed_w.val = vr_rdata;

	// status of a command that finishes without the datapath
	always_comb begin
		idle_res_w = '0;
		if (req.req_type == swmq_pkg::REQ_LOAD && load_take
			&& count_q >= CNT_W'(STORE_DEPTH)) begin
			idle_res_w.status = swmq_pkg::STAT_FULL;
		end else if (req.req_type == swmq_pkg::REQ_QUERY && !built_q) begin
			idle_res_w.status = swmq_pkg::STAT_NO_BLD;
		end
	end

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			swmq_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (swmq_pkg::req_kind_t'(req.req_type))
						swmq_pkg::REQ_BUILD:
							state_n = (count_q == '0) ? swmq_pkg::ST_DONE : swmq_pkg::ST_BLD_RD;
						swmq_pkg::REQ_QUERY:
							state_n = built_q ? swmq_pkg::ST_MUL : swmq_pkg::ST_DONE;
						default: state_n = swmq_pkg::ST_DONE;
					endcase
				end
			end
			swmq_pkg::ST_BLD_RD: begin
				if (idx_q == count_q - 1'b1) state_n = swmq_pkg::ST_BLD_SETTLE;
			end
			swmq_pkg::ST_BLD_SETTLE: begin
				if (wait_q == '0) state_n = swmq_pkg::ST_BLD_DRAIN;
			end
			swmq_pkg::ST_BLD_DRAIN: begin
				if (idx_q == count_q - 1'b1) state_n = swmq_pkg::ST_DONE;
			end
			swmq_pkg::ST_MUL: state_n = swmq_pkg::ST_BOUND;
			swmq_pkg::ST_BOUND: begin
				state_n = (prod_q < 0) ? swmq_pkg::ST_DONE : swmq_pkg::ST_SRCH_RD;
			end
			swmq_pkg::ST_SRCH_RD: begin
				if (lo_q < hi_q) begin
					state_n = swmq_pkg::ST_SRCH_CMP;
				end else if (sel_q) begin
					state_n = (lo_q > first_q) ? swmq_pkg::ST_PS_A : swmq_pkg::ST_DONE;
				end
			end
			swmq_pkg::ST_SRCH_CMP: state_n = swmq_pkg::ST_SRCH_RD;
			swmq_pkg::ST_PS_A:     state_n = swmq_pkg::ST_PS_B;
			swmq_pkg::ST_PS_B:     state_n = swmq_pkg::ST_PS_C;
			swmq_pkg::ST_PS_C:     state_n = swmq_pkg::ST_DIV;
			swmq_pkg::ST_DIV: begin
				if (step_q == DC_W'(1)) state_n = swmq_pkg::ST_DONE;
			end
			swmq_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_n = swmq_pkg::ST_IDLE;
			end
			default: state_n = swmq_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- outputs
	always_comb begin
		req_ready       = (state_q == swmq_pkg::ST_IDLE);
		cell_ctrl.clear = (state_q == swmq_pkg::ST_IDLE) && req_valid
			&& (req.req_type == swmq_pkg::REQ_BUILD);
		cell_ctrl.shift = (state_q == swmq_pkg::ST_BLD_DRAIN);

		// value RAM: append on load, write back sorted values on drain
		vr_we    = 1'b0;
		vr_waddr = count_q[AW-1:0];
		vr_wdata = req.load_value;
		if (state_q == swmq_pkg::ST_BLD_DRAIN) begin
			vr_we    = 1'b1;
			vr_waddr = idx_q[AW-1:0];
			vr_wdata = held_w[0].val;
		end else if (req_acc && (req.req_type == swmq_pkg::REQ_LOAD) && load_take
			&& (count_q < CNT_W'(STORE_DEPTH))) begin
			vr_we = 1'b1;
		end
		vr_raddr = (state_q == swmq_pkg::ST_BLD_RD) ? idx_q[AW-1:0] : mid_w[AW-1:0];

		pr_we    = (state_q == swmq_pkg::ST_BLD_DRAIN);
		pr_waddr = idx_q[AW-1:0];
		pr_wdata = drain_sum_w;
		pr_raddr = (state_q == swmq_pkg::ST_PS_A) ? AW'(past_q - 1'b1) : AW'(first_q - 1'b1);
	end

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swmq_pkg::ST_IDLE;
			thr_q       <= signed'(swmq_pkg::THRESH_RST);
			scale_q     <= signed'(swmq_pkg::SCALE_RST);
			count_q     <= '0;
			built_q     <= 1'b0;
			feed_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			feed_vld_s1 <= (state_q == swmq_pkg::ST_BLD_RD);

			if (cfg_valid) begin
				case (swmq_pkg::cfg_index_t'(cfg_index))
					swmq_pkg::CFG_THRESH: thr_q   <= signed'(cfg_data);
					swmq_pkg::CFG_SCALE:  scale_q <= signed'(cfg_data);
					default: ;
				endcase
			end

			if (req_acc) begin
				case (swmq_pkg::req_kind_t'(req.req_type))
					swmq_pkg::REQ_CLEAR: begin
						count_q <= '0;
						built_q <= 1'b0;
					end
					swmq_pkg::REQ_LOAD: begin
						if (load_take && (count_q < CNT_W'(STORE_DEPTH))) begin
							count_q <= count_q + 1'b1;
							built_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			// mark the store searchable once the sort has drained
			if (state_q == swmq_pkg::ST_BLD_DRAIN && state_n == swmq_pkg::ST_DONE) begin
				built_q <= 1'b1;
			end
			if (state_q == swmq_pkg::ST_IDLE && req_valid && state_n == swmq_pkg::ST_DONE
				&& req.req_type == swmq_pkg::REQ_BUILD) begin
				built_q <= 1'b1; // empty store
			end

			if (state_q == swmq_pkg::ST_DONE && state_n == swmq_pkg::ST_IDLE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			swmq_pkg::ST_IDLE: begin
				res_q    <= idle_res_w;
				idx_q    <= '0;
				acc_q    <= '0;
				center_q <= signed'(req.query_center);
				spread_q <= signed'(req.query_spread);
			end
			swmq_pkg::ST_BLD_RD: begin
				if (state_n == swmq_pkg::ST_BLD_SETTLE) begin
					idx_q  <= '0;
					wait_q <= {1'b0, count_q} + 2'd2;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			swmq_pkg::ST_BLD_SETTLE: wait_q <= wait_q - 1'b1;
			swmq_pkg::ST_BLD_DRAIN: begin
				idx_q <= idx_q + 1'b1;
				acc_q <= drain_sum_w;
			end
			swmq_pkg::ST_MUL: prod_q <= spread_q * scale_q;
			swmq_pkg::ST_BOUND: begin
				lo_b_q <= BW'(center_q) - {2'b00, prod_q[63:16]};
				hi_b_q <= BW'(center_q) + {2'b00, prod_q[63:16]};
				lo_q   <= '0;
				hi_q   <= count_q;
				sel_q  <= 1'b0;
			end
			swmq_pkg::ST_SRCH_RD: begin
				if (lo_q >= hi_q) begin
					if (!sel_q) begin
						// lower rank found, start the upper search
						first_q <= lo_q;
						sel_q   <= 1'b1;
						lo_q    <= '0;
						hi_q    <= count_q;
					end else begin
						past_q <= lo_q;
					end
				end
			end
			swmq_pkg::ST_SRCH_CMP: begin
				if (below_w) lo_q <= mid_w + 1'b1;
				else hi_q <= mid_w;
			end
			swmq_pkg::ST_PS_B: psa_q <= pr_rdata;
			swmq_pkg::ST_PS_C: begin
				dcnt_q            <= past_q - first_q;
				neg_q             <= win_sum_w[PS_W-1];
				dq_q              <= mag_w;
				rem_q             <= '0;
				step_q            <= DC_W'(PS_W);
				res_q.in_count    <= swmq_pkg::COUNT_W'(past_q - first_q);
				res_q.window_sum  <= swmq_pkg::SUM_W'({{(64-PS_W){win_sum_w[PS_W-1]}},
					win_sum_w});
				res_q.mean_valid  <= 1'b1;
			end
			swmq_pkg::ST_DIV: begin
				rem_q  <= rem_n_w;
				dq_q   <= dq_n_w;
				step_q <= step_q - 1'b1;
				if (step_q == DC_W'(1)) begin
					res_q.window_mean <= neg_q ? swmq_pkg::MEAN_W'(~dq_n_w + 1'b1)
						: swmq_pkg::MEAN_W'(dq_n_w);
				end
			end
			swmq_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) rsp_q <= res_q;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- stores
	swmq_ram #(
		.WIDTH (VW),
		.DEPTH (STORE_DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_waddr),
		.wdata (vr_wdata),
		.raddr (vr_raddr),
		.rdata (vr_rdata)
	);

	swmq_ram #(
		.WIDTH (PS_W),
		.DEPTH (STORE_DEPTH)
	) u_prefix_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (pr_waddr),
		.wdata (pr_wdata),
		.raddr (pr_raddr),
		.rdata (pr_rdata)
	);

	// ---------------------------------------------------------------- sort chain
	// Values enter at cell 0; each cell keeps the smaller and hands the larger to its
	// right-hand neighbour. After settling, cells 0..N-1 hold the store in ascending
	// order and a drain shifts them out through cell 0.
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		swmq_pkg::cell_word_t left_w;
		swmq_pkg::cell_word_t right_w;
		if (i == 0) begin : g_head
			assign left_w = feed_w;
		end else begin : g_body
			assign left_w = pass_w[i-1];
		end
		if (i == STORE_DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = held_w[i+1];
		end
		swmq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.left_in    (left_w),
			.right_held (right_w),
			.held       (held_w[i]),
			.pass       (pass_w[i])
		);
	end

endmodule
